>>> sv/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenOffset  = 56;
   localparam logic [7:0]  PadMark    = 8'h80;

   typedef enum logic [1:0] {
      CMD_ABSORB        = 2'd0,
      CMD_ABSORB_FINISH = 2'd1,
      CMD_FINISH        = 2'd2,
      CMD_FINISH_ALT    = 2'd3
   } cmd_type;

   // Work handed from the front end to the compression engine.
   typedef struct packed {
      logic        slot;      // which block buffer half holds the data
      logic        finish;    // pad and emit digest after this
      logic [5:0]  fill;      // bytes of message in the block (0..63), only when finish
      logic        full;      // block is a complete 64-byte block
      logic [63:0] bit_len;   // message length in bits at finish
   } job_type;

   localparam logic [31:0] InitValue [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

>>> sv/sha_ram.sv
`timescale 1ns / 1ps
module sha_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/sha_front.sv
`timescale 1ns / 1ps
// Byte packer: write bytes into the current buffer half, post a job per full
// block or finish.
module sha_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_data_byte,
   output logic             buf_wr_en,
   output logic [6:0]       buf_wr_addr,
   output logic [7:0]       buf_wr_data,
   output logic             job_valid,
   output sha_pkg::job_type job,
   input  logic             job_stall,
   input  logic             slot_free
);
   import sha_pkg::*;

   logic [63:0] bit_len_ff, bit_len_in;
   logic        slot_ff, slot_in;
   logic        accept;
   logic        absorb;
   logic        fin;
   logic [5:0]  pos;
   logic        full;

   assign pos    = bit_len_ff[8:3];
   assign absorb = (req_cmd == CMD_ABSORB) || (req_cmd == CMD_ABSORB_FINISH);
   assign fin    = (req_cmd != CMD_ABSORB);
   assign full   = absorb && (pos == 6'd63);

   // Hold while the queue is full or the current half is still claimed by a job.
   assign req_stall = job_stall || !slot_free;
   assign accept    = req_valid && !req_stall;

   assign buf_wr_en   = accept && absorb;
   assign buf_wr_addr = {slot_ff, pos};
   assign buf_wr_data = req_data_byte;

   assign job_valid   = accept && (full || fin);
   assign job.slot    = slot_ff;
   assign job.finish  = fin;
   assign job.full    = full;
   assign job.fill    = absorb ? pos + 6'd1 : pos;
   assign job.bit_len = absorb ? bit_len_ff + 64'd8 : bit_len_ff;

   always_comb begin
      bit_len_in = bit_len_ff;
      slot_in    = slot_ff;
      if (accept) begin
         if (fin) begin
            bit_len_in = '0;
         end else begin
            bit_len_in = bit_len_ff + 64'd8;
         end
         if (full || fin) begin
            slot_in = !slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_len_ff <= '0;
         slot_ff    <= 1'b0;
      end else begin
         bit_len_ff <= bit_len_in;
         slot_ff    <= slot_in;
      end
   end
endmodule

>>> sv/sha_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between packer and engine.
module sha_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sha_pkg::job_type push_job,
   output logic             full,
   output logic             not_empty,
   output sha_pkg::job_type head,
   input  logic             pop
);
   import sha_pkg::*;

   job_type    ent_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = ent_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

>>> sv/sha_engine.sv
`timescale 1ns / 1ps
// Compression engine: load 16 words from buffer, run 64 rounds, fold,
// then pad blocks and emit the digest for finish jobs.
module sha_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  sha_pkg::job_type job,
   output logic             job_pop,
   output logic             slot_release,
   output logic             slot_release_id,
   output logic [6:0]       buf_rd_addr,
   input  logic [7:0]       buf_rd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import sha_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_FOLD  = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_NEXT  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] cv_ff [8];
   logic [31:0] rv_ff [8];
   logic [31:0] w_ff  [16];
   logic [6:0]  cnt_ff, cnt_in;     // byte index during load, round during rounds
   logic        pass_ff;            // 0 first padded block, 1 length block
   logic        extra_ff;           // a second padded block is needed
   logic        rd_pend_ff;
   logic [5:0]  rd_pos_ff;
   logic [2:0]  emit_ff;
   logic [5:0]  pos;
   logic [7:0]  pad_byte;
   logic [31:0] wt, w2, w15, s0, s1, t1, t2;
   logic [31:0] ra, re;
   logic [5:0]  rnd;
   logic [5:0]  ld_pos;
   logic        ld_real;
   logic [2:0]  lsel;

   assign rnd = cnt_ff[5:0];
   assign ra  = rv_ff[0];
   assign re  = rv_ff[4];
   assign w2  = w_ff[14];
   assign w15 = w_ff[1];
   assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
   assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign wt  = (rnd < 6'd16) ? w_ff[0] : s1 + w_ff[9] + s0 + w_ff[0];
   assign t1  = rv_ff[7] + (rotr(re, 6) ^ rotr(re, 11) ^ rotr(re, 25))
              + ((re & rv_ff[5]) ^ (~re & rv_ff[6])) + RoundConst[rnd] + wt;
   assign t2  = (rotr(ra, 2) ^ rotr(ra, 13) ^ rotr(ra, 22))
              + ((ra & rv_ff[1]) ^ (ra & rv_ff[2]) ^ (rv_ff[1] & rv_ff[2]));

   // Read byte for position cnt during load; data returns next cycle.
   assign ld_pos      = cnt_ff[5:0];
   assign ld_real     = (state_ff == ST_LOAD) && !cnt_ff[6];
   assign buf_rd_addr = {job.slot, ld_pos};

   // Compose the byte that goes into the schedule for the position read in the previous cycle.
   // A full block closed by its finishing byte puts the pad mark at the head of
   // the length block.
   assign pos  = rd_pos_ff;
   assign lsel = 3'(pos - 6'(LenOffset));
   always_comb begin
      pad_byte = 8'h00;
      if (!pass_ff) begin
         if (job.full || pos < job.fill) begin
            pad_byte = buf_rd_data;
         end else if (pos == job.fill) begin
            pad_byte = PadMark;
         end else if (!extra_ff && pos >= 6'(LenOffset)) begin
            pad_byte = job.bit_len[8'(7 - lsel) * 8 +: 8];
         end
      end else if (job.full && pos == 6'd0) begin
         pad_byte = PadMark;
      end else if (pos >= 6'(LenOffset)) begin
         pad_byte = job.bit_len[8'(7 - lsel) * 8 +: 8];
      end
   end

   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = cv_ff[emit_ff];
   assign rsp_word_index  = emit_ff;
   assign rsp_last_word   = (emit_ff == 3'd7);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      job_pop         = 1'b0;
      slot_release    = 1'b0;
      slot_release_id = job.slot;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (job_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               state_in = ST_ROUND;
               cnt_in   = '0;
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cnt_in = '0;
            if (!job.finish) begin
               state_in     = ST_IDLE;
               job_pop      = 1'b1;
               slot_release = 1'b1;
            end else if (extra_ff && !pass_ff) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall && emit_ff == 3'd7) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            state_in     = ST_IDLE;
            job_pop      = 1'b1;
            slot_release = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         emit_ff    <= '0;
         pass_ff    <= 1'b0;
         extra_ff   <= 1'b0;
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            cv_ff[i] <= InitValue[i];
         end
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= ld_real;
         if (state_ff == ST_IDLE && job_valid) begin
            pass_ff  <= 1'b0;
            extra_ff <= job.finish && (job.full || job.fill >= 6'(LenOffset));
         end
         if (state_ff == ST_FOLD) begin
            if (job.finish && extra_ff && !pass_ff) begin
               pass_ff <= 1'b1;
            end
            for (int i = 0; i < 8; i++) begin
               cv_ff[i] <= cv_ff[i] + rv_ff[i];
            end
         end
         if (state_ff == ST_EMIT && !rsp_stall) begin
            emit_ff <= emit_ff + 3'd1;
         end
         if (state_ff == ST_NEXT) begin
            for (int i = 0; i < 8; i++) begin
               cv_ff[i] <= InitValue[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= ld_pos;
      // Shift the byte into the schedule window; advance the window as each new
      // word starts, so word 0 ends up first.
      if (rd_pend_ff) begin
         w_ff[15] <= {w_ff[15][23:0], pad_byte};
         if (pos[1:0] == 2'd0 && pos != 6'd0) begin
            for (int i = 0; i < 15; i++) begin
               w_ff[i] <= w_ff[i + 1];
            end
         end
      end
      if (state_ff == ST_LOAD && cnt_ff == 7'd64) begin
         for (int i = 0; i < 8; i++) begin
            rv_ff[i] <= cv_ff[i];
         end
      end
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= wt;
         rv_ff[7] <= rv_ff[6];
         rv_ff[6] <= rv_ff[5];
         rv_ff[5] <= rv_ff[4];
         rv_ff[4] <= rv_ff[3] + t1;
         rv_ff[3] <= rv_ff[2];
         rv_ff[2] <= rv_ff[1];
         rv_ff[1] <= rv_ff[0];
         rv_ff[0] <= t1 + t2;
      end
   end
endmodule

>>> sv/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// Streaming SHA-256 hasher. Each request carries a command (absorb byte,
// absorb byte and finish, finish without byte; code 3 acts as finish) and a
// byte. Bytes fill one half of a two-block buffer RAM while the engine
// compresses the other half, so byte requests take one cycle each as long as
// the engine keeps up. For each block the engine loads it from the RAM a byte
// a cycle, runs 64 rounds, folds and dispatches; requests stall while both
// buffer halves are taken. A finish adds one or two padded blocks and then
// presents the eight digest words, word 0 first, big-endian, last_word on
// word 7; after that the chaining value returns to the initial hash for the
// next message.
module sha256_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   logic       buf_wr_en;
   logic [6:0] buf_wr_addr, buf_rd_addr;
   logic [7:0] buf_wr_data, buf_rd_data;
   logic       push, q_full, q_ne, pop;
   job_type    push_job, head;
   logic       rel, rel_id;
   logic [1:0] busy_ff, busy_in;
   logic       slot_ff;
   logic       slot_free;

   // Track which buffer half is claimed by a posted job.
   assign slot_free = !busy_ff[slot_ff];

   always_comb begin
      busy_in = busy_ff;
      if (rel) begin
         busy_in[rel_id] = 1'b0;
      end
      if (push) begin
         busy_in[push_job.slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         slot_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (push) begin
            slot_ff <= !push_job.slot;
         end
      end
   end

   sha_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_data_byte,
      .buf_wr_en, .buf_wr_addr, .buf_wr_data,
      .job_valid(push), .job(push_job), .job_stall(q_full), .slot_free
   );

   sha_ram #(.Width(8), .Depth(128)) u_buf (
      .clock, .wr_en(buf_wr_en), .wr_addr(buf_wr_addr), .wr_data(buf_wr_data),
      .rd_addr(buf_rd_addr), .rd_data(buf_rd_data)
   );

   sha_queue u_queue (
      .clock, .reset, .push, .push_job, .full(q_full), .not_empty(q_ne),
      .head, .pop
   );

   sha_engine u_engine (
      .clock, .reset, .job_valid(q_ne), .job(head), .job_pop(pop),
      .slot_release(rel), .slot_release_id(rel_id),
      .buf_rd_addr, .buf_rd_data,
      .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the streaming SHA-256 hasher. A directed table covers the
// empty message and every command code; two long messages hit the padding
// boundaries, and random short messages follow. Every digest word is checked
// against an in-bench SHA-256 model.
module testbench;
   import sha_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_ABSORB;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_stream_hasher_top u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   // Digest words still due from the block, oldest first.
   digest_word_type pending_words[$];

   // Hash state kept by the bench.
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [63:0] msg_bits;

   int fail_count = 0;
   int request_count = 0;
   int word_count = 0;
   int message_count = 0;
   longint cycle_count = 0;

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds over one 64-byte block and fold into hash_state.
   task automatic run_rounds(input logic [7:0] blk [64]);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int k = 0; k < 8; k++) v[k] = hash_state[k];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) hash_state[k] += v[k];
   endtask

   task automatic hash_init();
      for (int k = 0; k < 8; k++) hash_state[k] = InitValue[k];
      msg_bits = '0;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      int pos;
      pos = int'(msg_bits[8:3]);
      msg_block[pos] = b;
      msg_bits += 64'd8;
      if (pos == 63) run_rounds(msg_block);
   endtask

   // Pad, fold in the length, queue the eight digest words and restart.
   task automatic finish_digest();
      logic [7:0] pad [64];
      digest_word_type dw;
      int pos;
      pos = int'(msg_bits[8:3]);
      for (int k = 0; k < 64; k++) pad[k] = (k < pos) ? msg_block[k] : 8'h00;
      pad[pos] = PadMark;
      if (pos >= LenOffset) begin
         run_rounds(pad);
         for (int k = 0; k < 64; k++) pad[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) pad[LenOffset + k] = msg_bits[63 - 8*k -: 8];
      run_rounds(pad);
      for (int k = 0; k < 8; k++) begin
         dw.word = hash_state[k];
         dw.index = 3'(k);
         dw.last = (k == 7);
         pending_words.push_back(dw);
      end
      message_count++;
      hash_init();
   endtask

   task automatic predict_request(input logic [1:0] cmd, input logic [7:0] b);
      if (cmd == CMD_ABSORB) begin
         absorb_byte(b);
      end else begin
         if (cmd == CMD_ABSORB_FINISH) absorb_byte(b);
         finish_digest();
      end
   endtask

   // Drive one request, after a random gap for some requests, and hold it until accepted.
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] b);
      int gap;
      gap = (request_count % 97 < 40) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(cmd, b);
      request_count++;
   endtask

   // Send a message of random bytes closed by the given finishing command.
   task automatic send_message(input int len, input logic [1:0] fin);
      logic [1:0] fin_cmd;
      fin_cmd = fin;
      if (fin_cmd == CMD_ABSORB_FINISH && len == 0) fin_cmd = CMD_FINISH;
      for (int k = 0; k < len - (fin_cmd == CMD_ABSORB_FINISH); k++)
         send_request(CMD_ABSORB, 8'($urandom));
      send_request(fin_cmd, 8'($urandom));
   endtask

   // Receiver: stall at random, check each accepted word in order.
   initial begin
      int hold;
      digest_word_type want;
      @(negedge reset);
      forever begin
         hold = (word_count % 50 < 20) ? 0 : $urandom_range(0, 13);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         word_count++;
         if (pending_words.size() == 0) begin
            $error("unexpected digest word %h", rsp_digest_word);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_digest_word !== want.word) begin
               $error("digest_word expected %h got %h", want.word, rsp_digest_word);
               fail_count++;
            end
            if (rsp_word_index !== want.index) begin
               $error("word_index expected %0d got %0d", want.index, rsp_word_index);
               fail_count++;
            end
            if (rsp_last_word !== want.last) begin
               $error("last_word expected %0d got %0d", want.last, rsp_last_word);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: bound the run well past the slowest legal schedule.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] b;
   } stim_row_type;

   // Directed table: empty message ("abc" is typed in below), byte extremes,
   // the alternate finish code, byte ignored on finish.
   stim_row_type directed [] = '{
      '{CMD_FINISH, 8'hff},
      '{CMD_ABSORB, 8'h61}, '{CMD_ABSORB, 8'h62}, '{CMD_ABSORB_FINISH, 8'h63},
      '{CMD_ABSORB, 8'h00}, '{CMD_ABSORB, 8'hff}, '{CMD_FINISH_ALT, 8'h5a},
      '{CMD_ABSORB_FINISH, 8'hff}, '{CMD_FINISH_ALT, 8'h00},
      '{CMD_ABSORB, 8'haa}, '{CMD_ABSORB_FINISH, 8'h55}
   };

   initial begin
      hash_init();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_request(directed[i].cmd, directed[i].b);
         if (i == 0 && pending_words[0].word != 32'he3b0c442) begin
            $error("empty digest_word expected e3b0c442 got %h", pending_words[0].word);
            fail_count++;
         end
         if (i == 3 && pending_words[pending_words.size() - 8].word != 32'hba7816bf)
         begin
            $error("abc digest_word expected ba7816bf got %h",
                   pending_words[pending_words.size() - 8].word);
            fail_count++;
         end
      end
      // Padding boundaries: a length block of its own, and a full block
      // closed by its finishing byte.
      send_message(56, 2'($urandom_range(1, 3)));
      send_message(64, CMD_ABSORB_FINISH);
      req_valid <= 1'b0;
      // Drain all digests before continuing.
      while (pending_words.size() != 0) @(posedge clock);
      // Random short messages.
      while (request_count < 140) begin
         send_message($urandom_range(0, 12), 2'($urandom_range(1, 3)));
      end
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d requests, %0d messages, %0d digest words",
               request_count, message_count, word_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
